@@ hdl/qvl_pkg.sv @@
package qvl_pkg;

  // fixed field widths
  localparam int STATE_W  = 10;
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int RATE_W   = 16;
  localparam int CFG_INDEX_W = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_Q_RATE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_V_RATE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT = 2'd2;

  // configuration reset values
  localparam logic [RATE_W-1:0] Q_RATE_RESET   = 16'd6554;
  localparam logic [RATE_W-1:0] V_RATE_RESET   = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RESET = 16'd58982;

  typedef struct packed {
    logic [RATE_W-1:0] q_rate;
    logic [RATE_W-1:0] v_rate;
    logic [RATE_W-1:0] discount;
  } qvl_cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0]         current_state;
    logic [ACTION_W-1:0]        action_index;
    logic signed [VALUE_W-1:0]  reward;
    logic [STATE_W-1:0]         next_state;
    logic                       end_of_episode;
  } qvl_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] new_q;
    logic signed [VALUE_W-1:0] new_v;
  } qvl_result_t;

  // table write strobes
  typedef struct packed {
    logic q;
    logic v;
  } qvl_wr_en_t;

endpackage

@@ hdl/qvl_tables.sv @@
module qvl_tables import qvl_pkg::*; #(
  parameter int NUM_STATES  = 1024,
  parameter int NUM_ACTIONS = 8
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [$clog2(NUM_STATES*NUM_ACTIONS)-1:0] rd_q_addr,
  input  logic [$clog2(NUM_STATES)-1:0]             rd_s_addr,
  input  logic [$clog2(NUM_STATES)-1:0]             rd_ns_addr,
  input  qvl_wr_en_t                wr_en,
  input  logic [$clog2(NUM_STATES*NUM_ACTIONS)-1:0] wr_q_addr,
  input  logic [$clog2(NUM_STATES)-1:0]             wr_v_addr,
  input  logic signed [VALUE_W-1:0] wr_q_data,
  input  logic signed [VALUE_W-1:0] wr_v_data,
  output logic signed [VALUE_W-1:0] old_q,
  output logic signed [VALUE_W-1:0] old_v,
  output logic signed [VALUE_W-1:0] next_v
);

  localparam int Q_DEPTH = NUM_STATES * NUM_ACTIONS;

  logic [VALUE_W-1:0] q_mem [Q_DEPTH];
  logic [VALUE_W-1:0] v_mem [NUM_STATES];

  // q table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en.q) begin
      q_mem[wr_q_addr] <= wr_q_data;
    end
    if (rd_en) begin
      old_q <= q_mem[rd_q_addr];
    end
  end

  // v table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en.v) begin
      v_mem[wr_v_addr] <= wr_v_data;
    end
    if (rd_en) begin
      old_v  <= v_mem[rd_s_addr];
      next_v <= v_mem[rd_ns_addr];
    end
  end

endmodule

@@ hdl/qvl_update.sv @@
module qvl_update import qvl_pkg::*; (
  input  logic                      clk,
  input  qvl_cfg_t                  cfg,
  input  logic signed [VALUE_W-1:0] reward,
  input  logic                      end_of_episode,
  input  logic signed [VALUE_W-1:0] old_q,
  input  logic signed [VALUE_W-1:0] old_v,
  input  logic signed [VALUE_W-1:0] next_v,
  output logic signed [VALUE_W-1:0] new_q,
  output logic signed [VALUE_W-1:0] new_v
);

  logic signed [48:0] gv_prod;
  logic signed [32:0] gv;
  logic signed [33:0] target;
  logic signed [34:0] diff_q;
  logic signed [34:0] diff_v;
  logic signed [51:0] step_q_prod;
  logic signed [51:0] step_v_prod;

  // old value plus floored step, clamped to 32 bits
  function automatic logic signed [VALUE_W-1:0] add_sat(logic signed [VALUE_W-1:0] old,
                                                        logic signed [51:0] prod);
    logic signed [35:0] step;
    logic signed [36:0] sum;
    step = prod[51:16];
    sum  = {{5{old[VALUE_W-1]}}, old} + {step[35], step};
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
      return sum[31:0];
    end else if (sum[36]) begin
      return {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_W-1){1'b1}}};
    end
  endfunction

  // discounted next-state value
  always_ff @(posedge clk) begin
    gv_prod <= $signed({1'b0, cfg.discount}) * next_v;
  end

  // target and differences to the old entries
  assign gv = gv_prod[48:16];

  always_comb begin
    if (end_of_episode) begin
      target = {{2{reward[VALUE_W-1]}}, reward};
    end else begin
      target = {{2{reward[VALUE_W-1]}}, reward} + {gv[32], gv};
    end
  end

  always_ff @(posedge clk) begin
    diff_q <= {target[33], target} - {{3{old_q[VALUE_W-1]}}, old_q};
    diff_v <= {target[33], target} - {{3{old_v[VALUE_W-1]}}, old_v};
  end

  // scaled steps
  always_ff @(posedge clk) begin
    step_q_prod <= $signed({1'b0, cfg.q_rate}) * diff_q;
    step_v_prod <= $signed({1'b0, cfg.v_rate}) * diff_v;
  end

  // saturating write-back values
  assign new_q = add_sat(old_q, step_q_prod);
  assign new_v = add_sat(old_v, step_v_prod);

endmodule

@@ hdl/tabular_qv_learning_update.sv @@
// Flow: an accepted transfer passes ST_READ, ST_TARGET and ST_STEP, and in ST_WRITE
//   is written back and registered on result once the output is free. One transition at
//   a time: each one reads, updates and writes back the q and v table memories before the
//   next one may read them. Reset: rates and discount return to their defaults, then a
//   clearing pass zeroes both tables with item_stall high; configuration writes are
//   taken throughout.
module tabular_qv_learning_update import qvl_pkg::*; #(
  parameter int NUM_STATES  = 1024,
  parameter int NUM_ACTIONS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  qvl_item_t              item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output qvl_result_t            result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]      cfg_data
);

  localparam int SW      = $clog2(NUM_STATES);
  localparam int AW      = $clog2(NUM_ACTIONS);
  localparam int Q_DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int QW      = $clog2(Q_DEPTH);
  localparam int SRW     = (SW > STATE_W) ? SW : STATE_W;
  localparam int ARW     = (AW > ACTION_W) ? AW : ACTION_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_TARGET,
    ST_STEP,
    ST_WRITE
  } state_t;

  state_t                    state;
  logic [QW-1:0]             clr_addr;
  logic [QW-1:0]             q_addr;
  logic [SW-1:0]             v_addr;
  logic signed [VALUE_W-1:0] reward;
  logic                      end_of_episode;
  qvl_cfg_t                  cfg;

  logic                      accept;
  logic                      out_free;
  logic                      write_fire;
  logic                      clearing;
  logic [SW-1:0]             s_in;
  logic [SW-1:0]             ns_in;
  logic [AW-1:0]             a_in;
  logic [QW-1:0]             q_addr_in;
  qvl_wr_en_t                wr_en;
  logic [QW-1:0]             wr_q_addr;
  logic [SW-1:0]             wr_v_addr;
  logic signed [VALUE_W-1:0] wr_q_data;
  logic signed [VALUE_W-1:0] wr_v_data;
  logic signed [VALUE_W-1:0] old_q;
  logic signed [VALUE_W-1:0] old_v;
  logic signed [VALUE_W-1:0] next_v;
  logic signed [VALUE_W-1:0] new_q;
  logic signed [VALUE_W-1:0] new_v;

  // state index modulo the table size, by shifted compare and subtract
  function automatic logic [SW-1:0] wrap_state(logic [STATE_W-1:0] x);
    logic [SRW-1:0] r;
    r = SRW'(x);
    for (int k = STATE_W - 1; k >= 0; k--) begin
      if ((NUM_STATES << k) < (1 << STATE_W)) begin
        if (r >= SRW'(NUM_STATES << k)) begin
          r = r - SRW'(NUM_STATES << k);
        end
      end
    end
    return SW'(r);
  endfunction

  // action index modulo the action count
  function automatic logic [AW-1:0] wrap_action(logic [ACTION_W-1:0] x);
    logic [ARW-1:0] r;
    r = ARW'(x);
    for (int k = ACTION_W - 1; k >= 0; k--) begin
      if ((NUM_ACTIONS << k) < (1 << ACTION_W)) begin
        if (r >= ARW'(NUM_ACTIONS << k)) begin
          r = r - ARW'(NUM_ACTIONS << k);
        end
      end
    end
    return AW'(r);
  endfunction

  // handshakes
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign write_fire = (state == ST_WRITE) && out_free;
  assign clearing   = (state == ST_CLEAR);
  assign cfg_ready  = 1'b1;

  // read addresses straight from the incoming transfer
  assign s_in      = wrap_state(item.current_state);
  assign ns_in     = wrap_state(item.next_state);
  assign a_in      = wrap_action(item.action_index);
  assign q_addr_in = QW'(s_in) * QW'(NUM_ACTIONS) + QW'(a_in);

  // write port: clearing pass or write-back
  always_comb begin
    wr_en.q = clearing || write_fire;
    wr_en.v = (clearing && (clr_addr < QW'(NUM_STATES))) || write_fire;
    if (clearing) begin
      wr_q_addr = clr_addr;
      wr_v_addr = clr_addr[SW-1:0];
      wr_q_data = '0;
      wr_v_data = '0;
    end else begin
      wr_q_addr = q_addr;
      wr_v_addr = v_addr;
      wr_q_data = new_q;
      wr_v_data = new_v;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.q_rate   <= Q_RATE_RESET;
      cfg.v_rate   <= V_RATE_RESET;
      cfg.discount <= DISCOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_Q_RATE:   cfg.q_rate   <= cfg_data;
        CFG_V_RATE:   cfg.v_rate   <= cfg_data;
        CFG_DISCOUNT: cfg.discount <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, transition hold registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      // result valid rises on write-back, drops once the transfer is taken
      if (write_fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == QW'(Q_DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + QW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state          <= ST_READ;
            q_addr         <= q_addr_in;
            v_addr         <= s_in;
            reward         <= item.reward;
            end_of_episode <= item.end_of_episode;
          end
        end
        ST_READ:   state <= ST_TARGET;
        ST_TARGET: state <= ST_STEP;
        ST_STEP:   state <= ST_WRITE;
        ST_WRITE: begin
          if (out_free) begin
            result.new_q <= new_q;
            result.new_v <= new_v;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  qvl_tables #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_tables (
    .clk        (clk),
    .rd_en      (accept),
    .rd_q_addr  (q_addr_in),
    .rd_s_addr  (s_in),
    .rd_ns_addr (ns_in),
    .wr_en      (wr_en),
    .wr_q_addr  (wr_q_addr),
    .wr_v_addr  (wr_v_addr),
    .wr_q_data  (wr_q_data),
    .wr_v_data  (wr_v_data),
    .old_q      (old_q),
    .old_v      (old_v),
    .next_v     (next_v)
  );

  qvl_update u_update (
    .clk            (clk),
    .cfg            (cfg),
    .reward         (reward),
    .end_of_episode (end_of_episode),
    .old_q          (old_q),
    .old_v          (old_v),
    .next_v         (next_v),
    .new_q          (new_q),
    .new_v          (new_v)
  );

endmodule

@@ test/tb_tabular_qv_learning_update.sv @@
module tb_tabular_qv_learning_update import qvl_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STATES      = 1024;
  localparam int NUM_ACTIONS     = 8;
  localparam int Q_SLOT_W        = $clog2(NUM_STATES*NUM_ACTIONS);
  localparam int STATE_POOL      = 16;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 146;
  localparam int IDLE_PERCENT    = 27;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;
  // limit covers the clearing pass after reset, which steps through all NUM_STATES*NUM_ACTIONS q entries
  localparam int WATCHDOG_LIMIT  = 50000;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [RATE_W-1:0]      RATE_FULL  = 16'hffff;
  localparam logic [RATE_W-1:0]      RATE_NONE  = 16'h0000;

  localparam logic signed [VALUE_W-1:0] REWARD_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] REWARD_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] REWARD_ONE = 32'sh0001_0000;

  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  qvl_item_t              item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  qvl_result_t            result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0]      cfg_data = '0;

  tabular_qv_learning_update #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted table contents and register values
  int          q_table [NUM_STATES*NUM_ACTIONS];
  int          v_table [NUM_STATES];
  logic [RATE_W-1:0] q_rate_reg   = Q_RATE_RESET;
  logic [RATE_W-1:0] v_rate_reg   = V_RATE_RESET;
  logic [RATE_W-1:0] discount_reg = DISCOUNT_RESET;

  qvl_item_t   pending_items[$];
  qvl_result_t expected_updates[$];

  bit item_taken;
  bit cfg_taken;
  bit steady_stretch;
  bit hold_off_request;
  int hold_off_left;
  int quiet_cycles;

  int transitions;
  int terminal_transitions;
  int saturated_updates;
  int results_checked;
  int register_writes;
  int mismatches;

  // move old value toward target by rate, floor shift then clamp to 32 bits
  function automatic int approach_target(int old_value, longint target,
                                         logic [RATE_W-1:0] rate);
    longint rate_l;
    longint old_l;
    longint moved;
    rate_l = longint'(rate);
    old_l  = longint'(old_value);
    moved  = old_l + ((rate_l * (target - old_l)) >>> 16);
    if (moved > VALUE_MAX) begin
      saturated_updates++;
      return int'(VALUE_MAX);
    end
    if (moved < VALUE_MIN) begin
      saturated_updates++;
      return int'(VALUE_MIN);
    end
    return int'(moved);
  endfunction

  // update both tables for one transition, return the new q and v
  function automatic qvl_result_t apply_transition(qvl_item_t t);
    logic [Q_SLOT_W-1:0] q_slot;
    longint      target;
    longint      gamma;
    longint      v_next;
    qvl_result_t upd;
    q_slot = Q_SLOT_W'(int'(t.current_state) * NUM_ACTIONS + int'(t.action_index));
    target = longint'(t.reward);
    if (!t.end_of_episode) begin
      gamma  = longint'(discount_reg);
      v_next = longint'(v_table[t.next_state]);
      target += (gamma * v_next) >>> 16;
    end else begin
      terminal_transitions++;
    end
    upd.new_q = approach_target(q_table[q_slot], target, q_rate_reg);
    upd.new_v = approach_target(v_table[t.current_state], target, v_rate_reg);
    q_table[q_slot]          = upd.new_q;
    v_table[t.current_state] = upd.new_v;
    return upd;
  endfunction

  function automatic qvl_item_t make_transition(logic [STATE_W-1:0] s,
                                                logic [ACTION_W-1:0] a,
                                                logic signed [VALUE_W-1:0] r,
                                                logic [STATE_W-1:0] ns,
                                                logic eop);
    qvl_item_t t;
    t.current_state  = s;
    t.action_index   = a;
    t.reward         = r;
    t.next_state     = ns;
    t.end_of_episode = eop;
    return t;
  endfunction

  // most transitions revisit a small set of states so the tables build up
  function automatic qvl_item_t random_transition();
    qvl_item_t t;
    int        modest;
    t.current_state = ($urandom_range(0, 99) < 60) ?
                      STATE_W'($urandom_range(0, STATE_POOL-1)) :
                      STATE_W'($urandom_range(0, NUM_STATES-1));
    t.action_index = ACTION_W'($urandom_range(0, NUM_ACTIONS-1));
    case ($urandom_range(0, 9))
      0, 1:          t.next_state = t.current_state;
      2, 3, 4, 5, 6: t.next_state = STATE_W'($urandom_range(0, STATE_POOL-1));
      default:       t.next_state = STATE_W'($urandom_range(0, NUM_STATES-1));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t.reward = $urandom;
      8:          t.reward = REWARD_MAX;
      9:          t.reward = REWARD_MIN;
      default: begin
        modest = $urandom_range(0, 32'h0010_0000);
        t.reward = modest - 32'sh0008_0000;
      end
    endcase
    t.end_of_episode = ($urandom_range(0, 3) == 0);
    return t;
  endfunction

  function automatic logic [RATE_W-1:0] random_rate();
    case ($urandom_range(0, 19))
      0, 1, 2: return RATE_NONE;
      3, 4, 5: return RATE_FULL;
      default: return RATE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // append one transition to the sender queue
  task automatic queue_item(input qvl_item_t t);
    pending_items.insert(pending_items.size(), t);
  endtask

  // sender: next pending item once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      item_taken = 1'b0;
      if (pending_items.size() > 0 &&
          (steady_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_request) begin
      hold_off_request = 1'b0;
      hold_off_left    = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady_stretch && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // monitor: check results, predict accepted items, track register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_checked++;
        if (expected_updates.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got new_q %0d new_v %0d",
                   $time, result.new_q, result.new_v);
        end else begin
          qvl_result_t want;
          want = expected_updates.pop_front();
          if (result.new_q !== want.new_q) begin
            mismatches++;
            $display("%0t: new_q mismatch, expected %0d, got %0d",
                     $time, want.new_q, result.new_q);
          end
          if (result.new_v !== want.new_v) begin
            mismatches++;
            $display("%0t: new_v mismatch, expected %0d, got %0d",
                     $time, want.new_v, result.new_v);
          end
        end
      end
      if (item_valid && !item_stall) begin
        expected_updates.insert(expected_updates.size(), apply_transition(item));
        transitions++;
        item_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_Q_RATE:   q_rate_reg   = cfg_data;
          CFG_V_RATE:   v_rate_reg   = cfg_data;
          CFG_DISCOUNT: discount_reg = cfg_data;
          default: ;
        endcase
        register_writes++;
        cfg_taken = 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_updates.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [RATE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid <= 1'b0;
  endtask

  // wait until every item went in and every result came back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_updates.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default rates, items held off by the clearing pass
    queue_item(make_transition(10'd0, 3'd0, REWARD_ONE, 10'd0, 1'b1));
    queue_item(make_transition(10'd0, 3'd0, 32'sd0, 10'd0, 1'b0));
    queue_item(make_transition(10'd1023, 3'd7, -REWARD_ONE, 10'd0, 1'b0));
    queue_item(make_transition(10'd512, 3'd4, REWARD_MAX, 10'd1023, 1'b1));
    queue_item(make_transition(10'd0, 3'd0, REWARD_MIN, 10'd512, 1'b0));
    wait_drained();

    // full rates: drive values into saturation both ways
    write_reg(CFG_Q_RATE, RATE_FULL);
    write_reg(CFG_V_RATE, RATE_FULL);
    write_reg(CFG_DISCOUNT, RATE_FULL);
    write_reg(CFG_UNUSED, 16'h5a5a);
    queue_item(make_transition(10'd2, 3'd1, REWARD_MAX, 10'd2, 1'b1));
    queue_item(make_transition(10'd2, 3'd1, REWARD_MAX, 10'd2, 1'b0));
    queue_item(make_transition(10'd3, 3'd6, REWARD_MAX, 10'd2, 1'b0));
    queue_item(make_transition(10'd4, 3'd2, REWARD_MIN, 10'd4, 1'b1));
    queue_item(make_transition(10'd4, 3'd2, REWARD_MIN, 10'd4, 1'b0));
    queue_item(make_transition(10'd5, 3'd5, 32'sd0, 10'd3, 1'b0));
    queue_item(make_transition(10'd1023, 3'd7, REWARD_MAX, 10'd1023, 1'b0));
    queue_item(make_transition(10'd1022, 3'd0, REWARD_MIN, 10'd4, 1'b0));
    wait_drained();

    // zero rates leave the tables as they are
    write_reg(CFG_Q_RATE, RATE_NONE);
    write_reg(CFG_V_RATE, RATE_NONE);
    write_reg(CFG_DISCOUNT, RATE_NONE);
    queue_item(make_transition(10'd2, 3'd1, REWARD_MIN, 10'd2, 1'b0));
    queue_item(make_transition(10'd0, 3'd3, REWARD_MAX, 10'd1023, 1'b1));
    wait_drained();

    write_reg(CFG_Q_RATE, RATE_FULL);
    write_reg(CFG_V_RATE, 16'd1);
    queue_item(make_transition(10'd4, 3'd2, REWARD_MAX, 10'd2, 1'b0));
    queue_item(make_transition(10'd3, 3'd6, REWARD_MIN, 10'd3, 1'b0));
    wait_drained();

    // random phases, each under its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(CFG_Q_RATE, random_rate());
      write_reg(CFG_V_RATE, random_rate());
      write_reg(CFG_DISCOUNT, random_rate());
      @(posedge clk);
      steady_stretch = (phase == 1);
      if (phase == 2) hold_off_request = 1'b1;
      repeat (ITEMS_PER_PHASE) queue_item(random_transition());
      wait_drained();
      steady_stretch = 1'b0;
    end

    $display("covered %0d transitions (%0d terminal), %0d saturated updates, %0d reg writes",
             transitions, terminal_transitions, saturated_updates, register_writes);
    $display("checked %0d results with %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
